// ===== sv/ghe_pkg.sv =====
// ----------------------------------------------------------------------------
// Gray histogram engine package
// Shared constants, request codes, pipeline types and the gray level function.
// ----------------------------------------------------------------------------
package ghe_pkg;

	localparam int BINS    = 256;
	localparam int BIN_AW  = $clog2(BINS);
	localparam int COUNT_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [1:0] REQ_PIXEL      = 2'd0;
	localparam logic [1:0] REQ_READ       = 2'd1;
	localparam logic [1:0] REQ_READ_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]        req;
		logic [BIN_AW-1:0] addr;
		logic [7:0]        gray;
	} ghe_beat_t;

	function automatic logic [7:0] gray_of(input logic [31:0] argb);
		logic [12:0] sum;
		sum = 13'(argb[23:16]) * 13'd11 + 13'({argb[15:8], 4'b0000})
			+ 13'(argb[7:0]) * 13'd5;
		return sum[12:5];
	endfunction

endpackage

// ===== sv/ghe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, read-first read.
// ----------------------------------------------------------------------------
module ghe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/gray_histogram_engine_top.sv =====
// ----------------------------------------------------------------------------
// Gray histogram engine
// A request is taken in every cycle; busy stays low and the receiver cannot stall.
// Done and the result come from the result register, which follows the
// registered memory read and request stage. Back-to-back updates of one bin
// are forwarded from the previous write. Reset clears all bins at once
// through per-bin valid bits.
// ----------------------------------------------------------------------------
module gray_histogram_engine_top
	import ghe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [31:0] pixel_argb,
	input  logic [7:0]  bin_index,
	output logic        done,
	output logic [7:0]  gray_level,
	output logic [31:0] gray_pixel,
	output logic [31:0] bin_count
);

	logic [7:0]         gray_s0;
	logic [BIN_AW-1:0]  addr_s0;
	logic               valid_s1;
	ghe_beat_t          beat_s1;
	logic [COUNT_W-1:0] rdata;
	logic [COUNT_W-1:0] old_count;
	logic [COUNT_W-1:0] wr_data;
	logic               wr_en;
	logic               is_pixel;
	logic               is_clear;
	logic               is_read;
	logic               fwd_valid_q;
	logic [BIN_AW-1:0]  fwd_addr_q;
	logic [COUNT_W-1:0] fwd_data_q;
	logic [BINS-1:0]    bin_valid_q;
	logic               done_q;
	logic [7:0]         gray_level_q;
	logic [31:0]        gray_pixel_q;
	logic [31:0]        bin_count_q;

	assign busy    = 1'b0;
	assign gray_s0 = gray_of(pixel_argb);
	assign addr_s0 = (req_type == REQ_PIXEL) ? BIN_AW'(gray_s0) : BIN_AW'(bin_index);

	ghe_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(BINS)
	) u_bins (
		.clk  (clk),
		.we   (wr_en),
		.waddr(beat_s1.addr),
		.wdata(wr_data),
		.raddr(addr_s0),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		beat_s1.req  <= req_type;
		beat_s1.addr <= addr_s0;
		beat_s1.gray <= gray_s0;
	end

	assign is_pixel = beat_s1.req == REQ_PIXEL;
	assign is_clear = beat_s1.req == REQ_READ_CLEAR;
	assign is_read  = (beat_s1.req == REQ_READ) || (beat_s1.req == REQ_READ_CLEAR);
	assign wr_en    = valid_s1 && (is_pixel || is_clear);

	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == beat_s1.addr)) begin
			old_count = fwd_data_q;
		end else if (bin_valid_q[beat_s1.addr]) begin
			old_count = rdata;
		end else begin
			old_count = '0;
		end
		if (is_clear) begin
			wr_data = '0;
		end else if (old_count == COUNT_MAX) begin
			wr_data = old_count;
		end else begin
			wr_data = old_count + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			bin_valid_q <= '0;
			done_q      <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
			done_q      <= valid_s1;
			if (wr_en) begin
				bin_valid_q[beat_s1.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q   <= beat_s1.addr;
		fwd_data_q   <= wr_data;
		gray_level_q <= is_pixel ? beat_s1.gray : 8'd0;
		gray_pixel_q <= is_pixel ? {8'hFF, beat_s1.gray, beat_s1.gray, beat_s1.gray} : 32'd0;
		bin_count_q  <= is_read ? 32'(old_count) : 32'd0;
	end

	assign done       = done_q;
	assign gray_level = gray_level_q;
	assign gray_pixel = gray_pixel_q;
	assign bin_count  = bin_count_q;

`ifndef NO_ASSERTIONS
	a_done_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s1))
		else $error("Done strobe without a request in the update stage.");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> bin_valid_q[$past(beat_s1.addr)])
		else $error("Written bin not marked valid.");

	a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_valid_q |-> $past(wr_en))
		else $error("Forwarding entry valid without a preceding write.");

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (bin_count == 32'd0 || gray_pixel == 32'd0))
		else $error("Result carries both pixel and count data.");

	a_gray_pixel_form: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (gray_pixel == 32'd0
			|| gray_pixel == {8'hFF, gray_level, gray_level, gray_level}))
		else $error("Gray pixel does not match gray level.");
`endif

endmodule

// ===== test/gray_histogram_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// Gray histogram engine testbench
// Drives pixel, bin read, bin read-and-clear and unused requests into the
// engine and keeps its own histogram to predict every result. Each result
// beat is compared field by field with the oldest prediction. Directed beats
// cover the channel extremes and back-to-back updates of one bin. Random
// beats mix wide-range pixels with colors that pile into a few bins.
// ----------------------------------------------------------------------------
module gray_histogram_engine_top_tb;

	import ghe_pkg::*;

	localparam logic [1:0] REQ_UNUSED  = 2'd3;
	localparam int         CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic [7:0]  gray;
		logic [31:0] pixel;
		logic [31:0] count;
	} gray_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [31:0] pixel_argb;
	logic [7:0]  bin_index;
	logic        done;
	logic [7:0]  gray_level;
	logic [31:0] gray_pixel;
	logic [31:0] bin_count;

	logic [COUNT_W-1:0] hist_model [BINS];
	gray_result_t       pending_results [$];
	gray_result_t       oldest;
	int                 beats_accepted = 0;
	int                 mismatches = 0;
	int                 cycle_count = 0;
	bit                 sender_idles = 1'b0;
	logic [7:0]         last_gray_seen = 8'd0;

	gray_histogram_engine_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.pixel_argb(pixel_argb),
		.bin_index (bin_index),
		.done      (done),
		.gray_level(gray_level),
		.gray_pixel(gray_pixel),
		.bin_count (bin_count)
	);

	always #5 clk = ~clk;

	function automatic gray_result_t predict_gray_result(input logic [1:0] req,
			input logic [31:0] argb, input logic [7:0] idx);
		gray_result_t r;
		int unsigned  weighted;
		r = '0;
		case (req)
			REQ_PIXEL: begin
				weighted = 32'(argb[23:16]) * 11 + 32'(argb[15:8]) * 16
					+ 32'(argb[7:0]) * 5;
				r.gray   = 8'(weighted >> 5);
				r.pixel  = {8'hFF, r.gray, r.gray, r.gray};
				if (hist_model[r.gray] != {COUNT_W{1'b1}})
					hist_model[r.gray] = hist_model[r.gray] + COUNT_W'(1);
			end
			REQ_READ, REQ_READ_CLEAR: begin
				r.count = 32'(hist_model[idx]);
				if (req == REQ_READ_CLEAR)
					hist_model[idx] = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at cycle %0d: %s expected %h got %h",
				cycle_count, what, want, got);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (start && !busy) begin
				pending_results.push_back(
					predict_gray_result(req_type, pixel_argb, bin_index));
				if (req_type == REQ_PIXEL)
					last_gray_seen = pending_results[$].gray;
				beats_accepted++;
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("unexpected result beat", 32'd0, 32'd1);
				end else begin
					oldest = pending_results.pop_front();
					if (gray_level !== oldest.gray)
						flag_mismatch("gray_level", 32'(oldest.gray), 32'(gray_level));
					if (gray_pixel !== oldest.pixel)
						flag_mismatch("gray_pixel", oldest.pixel, gray_pixel);
					if (bin_count !== oldest.count)
						flag_mismatch("bin_count", oldest.count, bin_count);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("FAIL gray_histogram_engine_top");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_beat(input logic [1:0] req, input logic [31:0] argb,
			input logic [7:0] idx);
		int target;
		if (sender_idles) begin
			while ($urandom_range(99) < 6) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start      <= 1'b1;
		req_type   <= req;
		pixel_argb <= argb;
		bin_index  <= idx;
		target = beats_accepted + 1;
		do
			@(negedge clk);
		while (beats_accepted != target);
	endtask

	function automatic logic [31:0] random_pixel();
		logic [31:0] palette [6];
		int unsigned pick;
		logic [7:0]  level;
		palette = '{32'h00808080, 32'h00FF0000, 32'h0000FF00, 32'h000000FF,
			32'h00102030, 32'h00F0E0D0};
		pick = $urandom_range(99);
		level = 8'($urandom);
		if (pick < 40)
			return $urandom;
		else if (pick < 70)
			return {8'($urandom), palette[$urandom_range(5)][23:0]};
		else if (pick < 85)
			return {8'($urandom), level, level, level};
		else
			return {8'($urandom), {8{1'($urandom)}}, {8{1'($urandom)}},
				{8{1'($urandom)}}};
	endfunction

	task automatic send_random_beat();
		int unsigned pick;
		logic [7:0]  idx;
		pick = $urandom_range(99);
		idx = ($urandom_range(99) < 60) ? last_gray_seen : 8'($urandom);
		if (pick < 70)
			send_beat(REQ_PIXEL, random_pixel(), 8'($urandom));
		else if (pick < 82)
			send_beat(REQ_READ, $urandom, idx);
		else if (pick < 94)
			send_beat(REQ_READ_CLEAR, $urandom, idx);
		else
			send_beat(REQ_UNUSED, $urandom, 8'($urandom));
	endtask

	task automatic test_directed_cases();
		sender_idles = 1'b0;
		send_beat(REQ_PIXEL, 32'h00000000, 8'h00);
		send_beat(REQ_PIXEL, 32'hFFFFFFFF, 8'hFF);
		send_beat(REQ_PIXEL, 32'hFF000000, 8'h00);
		send_beat(REQ_PIXEL, 32'h00FF0000, 8'h00);
		send_beat(REQ_PIXEL, 32'h0000FF00, 8'h00);
		send_beat(REQ_PIXEL, 32'h000000FF, 8'h00);
		send_beat(REQ_PIXEL, 32'h00FFFFFF, 8'h00);
		send_beat(REQ_READ, 32'hFFFFFFFF, 8'd0);
		send_beat(REQ_READ, 32'h00000000, 8'd255);
		send_beat(REQ_PIXEL, 32'h00FFFFFF, 8'd0);
		send_beat(REQ_READ_CLEAR, 32'h00000000, 8'd255);
		send_beat(REQ_READ, 32'h00000000, 8'd255);
		send_beat(REQ_PIXEL, 32'hFFFFFFFF, 8'd0);
		send_beat(REQ_READ, 32'h00000000, 8'd255);
		send_beat(REQ_UNUSED, 32'hFFFFFFFF, 8'd255);
		send_beat(REQ_READ_CLEAR, 32'h00000000, 8'd0);
		send_beat(REQ_READ_CLEAR, 32'h00000000, 8'd0);
		send_beat(REQ_READ, 32'h00000000, 8'd87);
		send_beat(REQ_READ, 32'h00000000, 8'd127);
		send_beat(REQ_READ, 32'h00000000, 8'd39);
		send_beat(REQ_READ, 32'h00000000, 8'd200);
		repeat (3)
			send_beat(REQ_PIXEL, 32'h00808080, 8'd0);
		send_beat(REQ_READ, 32'h00000000, 8'd128);
	endtask

	task automatic test_random_mix();
		sender_idles = 1'b1;
		repeat (1330)
			send_random_beat();
	endtask

	task automatic test_back_to_back_same_bins();
		int unsigned pick;
		logic [7:0]  level;
		sender_idles = 1'b0;
		repeat (400) begin
			pick = $urandom_range(99);
			level = 8'd128 + 8'($urandom_range(1));
			if (pick < 70)
				send_beat(REQ_PIXEL, {8'($urandom), level, level, level}, 8'($urandom));
			else if (pick < 85)
				send_beat(REQ_READ, $urandom, level);
			else
				send_beat(REQ_READ_CLEAR, $urandom, level);
		end
	endtask

	task automatic test_pause_until_drained();
		sender_idles = 1'b1;
		repeat (60)
			send_random_beat();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (60)
			send_random_beat();
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = REQ_PIXEL;
		pixel_argb = 32'd0;
		bin_index  = 8'd0;
		foreach (hist_model[i])
			hist_model[i] = '0;
		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_random_mix();
		test_back_to_back_same_bins();
		test_pause_until_drained();

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8)
			@(negedge clk);
		if (mismatches == 0)
			$display("PASS gray_histogram_engine_top");
		else
			$display("FAIL gray_histogram_engine_top");
		$finish;
	end

endmodule
